/* hw/rtl/rpa_pkg.sv */
`default_nettype none

package rpa_pkg;

  // Field widths of one request and one result, and of the pool size
  localparam int ModeW  = 2;
  localparam int SlotW  = 6;
  localparam int CountW = 16;
  localparam int StatW  = 2;
  localparam int PoolW  = 7;

  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // Request modes
  localparam logic [ModeW-1:0] MODE_ALLOC = 2'd0;
  localparam logic [ModeW-1:0] MODE_INCR  = 2'd1;
  localparam logic [ModeW-1:0] MODE_DECR  = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [StatW-1:0] ST_OVERFLOW  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch request, issue memory reads
    logic exec;      // update state, load result register
    logic clear;     // write one entry of the refill sweep
    logic restart;   // restart the refill sweep from entry zero
  } rpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // result register can take a new item
    logic clear_last;  // sweep is on its last entry
  } rpa_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/rpa_ctrl.sv */
`default_nettype none

module rpa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_wr_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rpa_pkg::rpa_sts_t sts_i,
  output rpa_pkg::rpa_cmd_t      cmd_o
);
  import rpa_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  // Sequence refill sweep, request capture and execution
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // A pool size write refills everything; hold off requests meanwhile
    if (cfg_wr_i) begin
      cmd_o.restart = 1'b1;
      cmd_o.clear   = 1'b0;
      cmd_o.capture = 1'b0;
      in_ready_o    = 1'b0;
      state_d       = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rpa_dp.sv */
`default_nettype none

module rpa_dp #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rpa_pkg::rpa_cmd_t           cmd_i,
  output rpa_pkg::rpa_sts_t                sts_o,
  input  wire logic [rpa_pkg::PoolW-1:0]   pool_count_i,
  input  wire logic [rpa_pkg::ModeW-1:0]   in_mode_i,
  input  wire logic [rpa_pkg::SlotW-1:0]   in_slot_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpa_pkg::SlotW-1:0]        out_slot_o,
  output logic [rpa_pkg::CountW-1:0]       out_count_o,
  output logic                             out_freed_o,
  output logic [rpa_pkg::StatW-1:0]        out_status_o
);
  import rpa_pkg::*;

  localparam int IdxW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DepthW = $clog2(MAX_SLOTS + 1);
  localparam int PoolReset = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  // Storage: free stack and reference counts
  logic [IdxW-1:0]   stack_mem [MAX_SLOTS];
  logic [CountW-1:0] count_mem [MAX_SLOTS];

  logic [DepthW-1:0] depth_q, depth_d;
  logic [IdxW-1:0]   clr_idx_q;
  logic [ModeW-1:0]  mode_q;
  logic [SlotW-1:0]  slot_q;
  logic [IdxW-1:0]   top_rd_q;
  logic [CountW-1:0] cnt_rd_q;

  logic              stack_we, count_we;
  logic [IdxW-1:0]   stack_wa, count_wa;
  logic [IdxW-1:0]   stack_wd;
  logic [CountW-1:0] count_wd;

  logic              res_push, res_pop, res_cnt_we;
  logic [SlotW-1:0]  res_slot;
  logic [CountW-1:0] res_count;
  logic              res_freed;
  logic [StatW-1:0]  res_status;

  logic out_valid_q;

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.clear_last = (clr_idx_q == IdxW'(MAX_SLOTS - 1));

  // Latch the request and read both memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= in_mode_i;
      slot_q   <= in_slot_i;
      cnt_rd_q <= count_mem[IdxW'(in_slot_i)];
      top_rd_q <= stack_mem[IdxW'(depth_q - DepthW'(1))];
    end
  end

  // Work out the result and the state update
  always_comb begin
    res_push   = 1'b0;
    res_pop    = 1'b0;
    res_cnt_we = 1'b0;
    res_slot   = slot_q;
    res_count  = '0;
    res_freed  = 1'b0;
    res_status = ST_OK;
    case (mode_q)
      MODE_ALLOC: begin
        if (depth_q == '0) begin
          res_status = ST_EMPTY;
          res_slot   = '0;
        end else begin
          res_pop    = 1'b1;
          res_cnt_we = 1'b1;
          res_slot   = SlotW'(top_rd_q);
          res_count  = CountW'(1);
        end
      end
      MODE_INCR, MODE_DECR: begin
        if ({1'b0, slot_q} >= pool_count_i || cnt_rd_q == '0) begin
          res_status = ST_NOT_ALLOC;
        end else if (mode_q == MODE_INCR) begin
          res_cnt_we = 1'b1;
          if (cnt_rd_q == CountMax) begin
            res_count  = CountMax;
            res_status = ST_OVERFLOW;
          end else begin
            res_count = cnt_rd_q + CountW'(1);
          end
        end else begin
          res_cnt_we = 1'b1;
          if (cnt_rd_q > CountW'(1)) begin
            res_count = cnt_rd_q - CountW'(1);
          end else begin
            res_freed = 1'b1;
            res_push  = (depth_q < DepthW'(MAX_SLOTS));
          end
        end
      end
      default: begin
        res_status = ST_NOT_ALLOC;
      end
    endcase
  end

  // Pick the write port source: refill sweep or request
  always_comb begin
    stack_we = 1'b0;
    stack_wa = clr_idx_q;
    stack_wd = clr_idx_q;
    count_we = 1'b0;
    count_wa = clr_idx_q;
    count_wd = '0;
    depth_d  = depth_q;
    if (cmd_i.clear) begin
      stack_we = 1'b1;
      count_we = 1'b1;
      depth_d  = DepthW'(pool_count_i);
    end else if (cmd_i.exec) begin
      stack_we = res_push;
      stack_wa = IdxW'(depth_q);
      stack_wd = IdxW'(slot_q);
      count_we = res_cnt_we;
      count_wa = res_pop ? top_rd_q : IdxW'(slot_q);
      count_wd = res_count;
      if (res_pop) begin
        depth_d = depth_q - DepthW'(1);
      end else if (res_push) begin
        depth_d = depth_q + DepthW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (count_we) begin
      count_mem[count_wa] <= count_wd;
    end
  end

  // Advance stack depth and sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DepthW'(PoolReset);
      clr_idx_q <= '0;
    end else begin
      depth_q <= depth_d;
      if (cmd_i.restart) begin
        clr_idx_q <= '0;
      end else if (cmd_i.clear) begin
        clr_idx_q <= sts_o.clear_last ? '0 : clr_idx_q + IdxW'(1);
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_slot_o   <= res_slot;
      out_count_o  <= res_count;
      out_freed_o  <= res_freed;
      out_status_o <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/refcounted_pool_allocator_unit.sv */
// Reference-counted slot pool allocator.
// Requests arrive on the s_axis stream: tdata[1:0] mode (allocate,
// increment, decrement), tdata[7:2] slot. Each request gives exactly one
// result on m_axis: slot, reference count after the request, freed flag
// and status (ok, pool empty, slot not allocated, count overflow).
// Timing: at the edge that accepts a request, its count and the stack top
// are read from the synchronous memories; once the result register is
// free, the state is written back and the result register loaded. The
// next request is taken only after that result is loaded, so a request is
// not taken while another one still waits to execute.
// When the receiver stalls, the result waits in its output register and
// one more request can be taken; that request then waits until the
// register is free.
// After reset, and after each write of the pool_count register over APB,
// a refill sweep rewrites every entry of the free stack and the count
// memory, one entry a cycle; s_axis_tready stays low meanwhile. Slot
// pool_count-1 is then the first to be allocated.
`default_nettype none

module refcounted_pool_allocator_unit #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] mode, [7:2] slot
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [5:0] slot_out, [21:6] ref_count,
                                           // [22] freed, [24:23] status
);
  import rpa_pkg::*;

  localparam int PoolReset = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  logic [PoolW-1:0]  pool_count_q;
  logic [PoolW-1:0]  wr_val;
  logic              cfg_wr;
  rpa_cmd_t          cmd;
  rpa_sts_t          sts;
  logic [SlotW-1:0]  out_slot;
  logic [CountW-1:0] out_count;
  logic              out_freed;
  logic [StatW-1:0]  out_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign wr_val = pwdata[PoolW-1:0];
  assign prdata = (paddr[2] == 1'b0) ? 32'(pool_count_q) : '0;

  // Clamp the written pool size into 1..MAX_SLOTS
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= PoolW'(PoolReset);
    end else if (cfg_wr) begin
      if (wr_val == '0) begin
        pool_count_q <= PoolW'(1);
      end else if (32'(wr_val) > 32'(MAX_SLOTS)) begin
        pool_count_q <= PoolW'(MAX_SLOTS);
      end else begin
        pool_count_q <= wr_val;
      end
    end
  end

  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pool_count_i (pool_count_q),
    .in_mode_i    (s_axis_tdata[1:0]),
    .in_slot_i    (s_axis_tdata[7:2]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_slot_o   (out_slot),
    .out_count_o  (out_count),
    .out_freed_o  (out_freed),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {7'd0, out_status, out_freed, out_count, out_slot};

endmodule

`default_nettype wire

/* dv/tb_refcounted_pool_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_refcounted_pool_allocator_unit;
  import rpa_pkg::*;

  localparam int PoolSlots = 64;
  localparam logic [2:0] ADDR_POOL_COUNT = 3'd0;
  // The mode encoding the block leaves unused
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              freed;
    logic [CountW-1:0] count;
    logic [SlotW-1:0]  slot;
  } pool_result_t;

  // Tracks free stack and counts; predicts one result per request
  class pool_tracker;
    int unsigned     pool_size;
    logic [SlotW-1:0] free_stack [PoolSlots];
    int unsigned     free_depth;
    logic [CountW-1:0] counts [PoolSlots];
    pool_result_t    pending_results [$];
    int              errors;

    function new();
      errors = 0;
      set_pool_count(PoolSlots);
    endfunction

    // Clamp the written size and refill the stack
    function void set_pool_count(logic [31:0] value);
      int unsigned v;
      v = value & 32'h7F;
      if (v < 1) v = 1;
      if (v > PoolSlots) v = PoolSlots;
      pool_size = v;
      for (int i = 0; i < PoolSlots; i++) begin
        free_stack[i] = i[SlotW-1:0];
        counts[i] = '0;
      end
      free_depth = pool_size;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Pick a random slot with a nonzero count, or -1
    function int any_live_slot();
      int live [$];
      for (int s = 0; s < int'(pool_size); s++)
        if (counts[s] != 0) live.push_back(s);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Apply one accepted request and queue its result
    function void note_request(logic [ModeW-1:0] mode, logic [SlotW-1:0] slot);
      pool_result_t r;
      r.status = ST_OK;
      r.freed  = 1'b0;
      r.count  = '0;
      r.slot   = slot;
      if (mode == MODE_ALLOC) begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
          r.slot   = '0;
        end else begin
          free_depth--;
          r.slot = free_stack[free_depth];
          counts[r.slot] = CountW'(1);
          r.count = CountW'(1);
        end
      end else if (mode != MODE_INCR && mode != MODE_DECR) begin
        r.status = ST_NOT_ALLOC;
      end else if (slot >= pool_size || counts[slot] == 0) begin
        r.status = ST_NOT_ALLOC;
      end else if (mode == MODE_INCR) begin
        if (counts[slot] == CountMax) begin
          r.status = ST_OVERFLOW;
        end else begin
          counts[slot]++;
        end
        r.count = counts[slot];
      end else begin
        counts[slot]--;
        r.count = counts[slot];
        if (counts[slot] == 0) begin
          r.freed = 1'b1;
          if (free_depth < PoolSlots) begin
            free_stack[free_depth] = slot;
            free_depth++;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [31:0] data);
      pool_result_t got;
      pool_result_t want;
      got = pool_result_t'(data[24:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.slot !== want.slot) report("slot_out", want.slot, got.slot);
      if (got.count !== want.count) report("ref_count", want.count, got.count);
      if (got.freed !== want.freed) report("freed", want.freed, got.freed);
      if (got.status !== want.status) report("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [1:0] mode, [7:2] slot
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [5:0] slot_out, [21:6] ref_count, [22] freed,
                               // [24:23] status

  pool_tracker tracker = new();
  bit          no_idle = 1'b0;

  refcounted_pool_allocator_unit #(
    .MAX_SLOTS(PoolSlots)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result side in bursts, with ready runs between
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(0, 12);
      end else begin
        m_axis_tready <= 1'b1;
        hold = $urandom_range(0, 20);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_request(input logic [ModeW-1:0] mode, input logic [SlotW-1:0] slot);
    s_axis_tdata  <= {slot, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(mode, slot);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_pool_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_POOL_COUNT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_pool_count(value);
  endtask

  // Mostly well-formed alloc/incr/decr on live slots, some noise
  task automatic run_random(input int n);
    int unsigned      pick;
    int               live;
    logic [ModeW-1:0] mode;
    logic [SlotW-1:0] slot;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      live = tracker.any_live_slot();
      slot = SlotW'($urandom());
      if (pick < 8) begin
        mode = ModeW'($urandom_range(0, 3));
      end else if (live < 0 || pick < 40) begin
        mode = MODE_ALLOC;
      end else begin
        slot = live[SlotW-1:0];
        mode = (pick < 67) ? MODE_INCR : MODE_DECR;
      end
      send_request(mode, slot);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unallocated slots, unused mode, alloc order, free and reuse
    send_request(MODE_INCR, 6'd5);
    send_request(MODE_DECR, 6'd63);
    send_request(MODE_UNUSED, 6'd63);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_ALLOC, 6'h3F);
    send_request(MODE_INCR, 6'd63);
    send_request(MODE_DECR, 6'd63);
    send_request(MODE_DECR, 6'd63);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_DECR, 6'd62);
    send_request(MODE_DECR, 6'd62);
    send_request(MODE_INCR, 6'd40);

    // Raise slot 63 in a back-to-back burst, then bring it part way down
    no_idle = 1'b1;
    repeat (170) send_request(MODE_INCR, 6'd63);
    repeat (8) send_request(MODE_DECR, 6'd63);
    no_idle = 1'b0;

    // Zero pool size is taken as one slot: empty pool and out-of-range slot
    settle();
    write_pool_count(32'd0);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_INCR, 6'd1);
    send_request(MODE_INCR, 6'd0);
    send_request(MODE_DECR, 6'd0);
    send_request(MODE_DECR, 6'd0);
    send_request(MODE_DECR, 6'd0);
    send_request(MODE_ALLOC, 6'd0);
    run_random(200);

    // Oversized value clamps to the full pool
    settle();
    write_pool_count(32'd127);
    run_random(300);

    settle();
    write_pool_count(32'd2);
    run_random(200);

    // Upper data bits are ignored
    settle();
    write_pool_count(32'hFFFF_FF85);
    run_random(200);

    settle();
    write_pool_count($urandom_range(3, 63));
    run_random(300);

    // Last part runs without idling
    settle();
    write_pool_count(32'd64);
    no_idle = 1'b1;
    run_random(250);

    settle();
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_dp.sv
hw/rtl/refcounted_pool_allocator_unit.sv
dv/tb_refcounted_pool_allocator_unit.sv
